// ----- rtl/spic_pkg.sv -----
// Shared types and constants for the split-input pointwise convolution block.
package spic_pkg;

    // Output-channel lanes working side by side; lane = out_channel low bits.
    localparam int NUM_LANES = 16;
    localparam int LANE_W    = 4;

    // Operation codes carried by an input request.
    localparam logic [1:0] OP_WEIGHT = 2'd0;
    localparam logic [1:0] OP_BIAS   = 2'd1;
    localparam logic [1:0] OP_PIXEL  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_IN_CHANNELS  = 2'd0;
    localparam logic [1:0] REG_OUT_CHANNELS = 2'd1;
    localparam logic [1:0] REG_BIAS_ENABLE  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPUTE,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic [5:0]         out_channel;
        logic [6:0]         in_channel;
        logic signed [7:0]  weight_value;
        logic signed [31:0] bias_value;
        logic signed [7:0]  inout_sample;
        logic signed [7:0]  res_sample;
        logic               last_pixel;
    } item_t;

    typedef struct packed {
        logic [5:0]         out_channel_index;
        logic signed [31:0] sum;
        logic               last_channel;
        logic               end_of_image;
    } result_t;

    // Table write broadcast to all lanes; each lane decodes its own hits.
    typedef struct packed {
        logic               weight_we;
        logic               bias_we;
        logic               second_half;
        logic [5:0]         oc;
        logic [5:0]         ic;
        logic signed [7:0]  weight_value;
        logic signed [31:0] bias_value;
    } wr_ctrl_t;

    // Accumulate control broadcast to all lanes.
    typedef struct packed {
        logic              upd_en;
        logic              first;
        logic              bias_en;
        logic signed [7:0] xa;
        logic signed [7:0] xb;
    } mac_ctrl_t;

endpackage

// ----- rtl/spic_lane.sv -----
// One output-channel lane: weight RAMs for both halves, bias and accumulators.
module spic_lane
    import spic_pkg::*;
#(
    parameter int PASSES  = 4,
    parameter int MAX_IN  = 64,
    parameter int LANE_ID = 0,
    localparam int PW     = (PASSES > 1) ? $clog2(PASSES) : 1
)
(
    input  logic            clk,
    input  wr_ctrl_t        wr,
    input  mac_ctrl_t       mac,
    input  logic [5:0]      rd_ch,
    input  logic [PW-1:0]   rd_pass,
    input  logic [PW-1:0]   sel_pass,
    output logic [31:0]     lane_sum
);

    localparam int DEPTH = PASSES * MAX_IN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;

    logic signed [7:0]  weight_a_reg [DEPTH];
    logic signed [7:0]  weight_b_reg [DEPTH];
    logic signed [7:0]  rd_a_reg;
    logic signed [7:0]  rd_b_reg;
    logic [31:0]        bias_reg [PASSES];
    logic [31:0]        acc_reg [PASSES];

    logic               wr_hit;
    logic [5:0]         wr_shift;
    logic [PW-1:0]      wr_pass;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic signed [15:0] prod_a;
    logic signed [15:0] prod_b;
    logic signed [16:0] prod_sum;
    logic [31:0]        base;
    logic [31:0]        acc_next;

    assign wr_hit   = (wr.oc[LANE_W-1:0] == LANE_W'(LANE_ID));
    assign wr_shift = wr.oc >> LANE_W;
    assign wr_pass  = wr_shift[PW-1:0];
    assign wr_addr  = AW'(wr_pass) * AW'(MAX_IN) + AW'(wr.ic[CW-1:0]);
    assign rd_addr  = AW'(rd_pass) * AW'(MAX_IN) + AW'(rd_ch[CW-1:0]);

    always_ff @(posedge clk)
    begin
        if (wr.weight_we && wr_hit && !wr.second_half)
        begin
            weight_a_reg[wr_addr] <= wr.weight_value;
        end
        rd_a_reg <= weight_a_reg[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.weight_we && wr_hit && wr.second_half)
        begin
            weight_b_reg[wr_addr] <= wr.weight_value;
        end
        rd_b_reg <= weight_b_reg[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.bias_we && wr_hit)
        begin
            bias_reg[wr_pass] <= wr.bias_value;
        end
    end

    // Two 8x8 products, summed and sign-extended into the wrapping accumulator.
    assign prod_a   = rd_a_reg * mac.xa;
    assign prod_b   = rd_b_reg * mac.xb;
    assign prod_sum = {prod_a[15], prod_a} + {prod_b[15], prod_b};

    always_comb
    begin
        if (mac.first)
        begin
            base = mac.bias_en ? bias_reg[sel_pass] : 32'd0;
        end
        else
        begin
            base = acc_reg[sel_pass];
        end
        acc_next = base + {{15{prod_sum[16]}}, prod_sum};
    end

    always_ff @(posedge clk)
    begin
        if (mac.upd_en)
        begin
            acc_reg[sel_pass] <= acc_next;
        end
    end

    assign lane_sum = acc_reg[sel_pass];

endmodule

// ----- rtl/spic_merge.sv -----
// Merge stage: picks one lane's sum per cycle into the result register while no result is held stalled.
module spic_merge
    import spic_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       lane_sum [NUM_LANES],
    input  logic              load,
    input  logic [LANE_W-1:0] sel_lane,
    input  logic [5:0]        index,
    input  logic              last,
    input  logic              eoi,
    input  logic              result_stall,
    output logic              free,
    output logic              result_valid,
    output result_t           result
);

    logic    valid_reg;
    result_t result_reg;

    assign free = !valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.out_channel_index <= index;
            result_reg.sum               <= lane_sum[sel_lane];
            result_reg.last_channel      <= last;
            result_reg.end_of_image      <= eoi;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ----- rtl/split_input_pointwise_conv_int8.sv -----
// Top level of the split-input int8 pointwise (1x1) convolution block.
//
// Requests come in on item/item_valid/item_stall. A pixel request (one
// input channel, one sample from each half) runs in PASSES passes, PASSES
// = ceil(MAX_OUT_CHANNELS/16): the block accepts it and reads the first
// weight pair, then in each pass each of the 16 lanes updates one of its
// output channels. A lane owns every 16th output channel and its two weight
// RAMs (one per input half) give one weight pair per cycle, which sets the
// pass count. After the request that completes a pixel, the merge stage
// sends out_channels sums, one per cycle when the result side does not
// stall, in output-channel order; new requests wait until the last sum
// sits in the result register. Sums wrap modulo 2^32.
// Tables need no clearing after reset; an entry must be written before a
// pixel reads it. Configuration is written on cfg_write_en and should only
// change while the block is idle.
module split_input_pointwise_conv_int8
    import spic_pkg::*;
#(
    parameter int MAX_IN_CHANNELS  = 64,
    parameter int MAX_OUT_CHANNELS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result
);

    localparam int PASSES = (MAX_OUT_CHANNELS + NUM_LANES - 1) / NUM_LANES;
    localparam int PW     = (PASSES > 1) ? $clog2(PASSES) : 1;
    localparam logic [PW-1:0] LAST_PASS = PW'(PASSES - 1);

    // configuration
    logic [6:0] in_channels_reg;
    logic [6:0] out_channels_reg;
    logic       bias_enable_reg;
    logic [6:0] n_in;
    logic [6:0] n_out;

    // control
    state_t        state_reg, state_next;
    logic [PW-1:0] pass_reg, pass_next;
    logic [5:0]    chan_pos_reg, chan_pos_next;
    logic [5:0]    drain_idx_reg, drain_idx_next;
    logic          first_reg, do_upd_reg, last_reg, eoi_reg;
    logic signed [7:0] xa_reg, xb_reg;

    logic          accept;
    logic          pixel_accept;
    logic          merge_free;
    logic          merge_load;
    logic          drain_last;
    logic [5:0]    drain_shift;
    logic [PW-1:0] rd_pass;
    logic [PW-1:0] sel_pass;
    logic          ic_half;
    logic          ic_ok;
    logic          oc_ok;
    wr_ctrl_t      wr;
    mac_ctrl_t     mac;
    logic [31:0]   lane_sum [NUM_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_channels_reg  <= 7'd64;
            out_channels_reg <= 7'd64;
            bias_enable_reg  <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_IN_CHANNELS:  in_channels_reg  <= cfg_data;
                REG_OUT_CHANNELS: out_channels_reg <= cfg_data;
                REG_BIAS_ENABLE:  bias_enable_reg  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // counts act as clamped to 1..max
    always_comb
    begin
        if (in_channels_reg == 7'd0)
            n_in = 7'd1;
        else if (in_channels_reg > 7'(MAX_IN_CHANNELS))
            n_in = 7'(MAX_IN_CHANNELS);
        else
            n_in = in_channels_reg;

        if (out_channels_reg == 7'd0)
            n_out = 7'd1;
        else if (out_channels_reg > 7'(MAX_OUT_CHANNELS))
            n_out = 7'(MAX_OUT_CHANNELS);
        else
            n_out = out_channels_reg;
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign pixel_accept = accept && (item.operation == OP_PIXEL);

    // table write decode; out-of-range addresses are dropped
    assign ic_half = (item.in_channel >= 7'(MAX_IN_CHANNELS));
    assign ic_ok   = ({1'b0, item.in_channel} < 8'(2 * MAX_IN_CHANNELS));
    assign oc_ok   = ({1'b0, item.out_channel} < 7'(MAX_OUT_CHANNELS));

    always_comb
    begin
        wr.weight_we    = accept && (item.operation == OP_WEIGHT) && oc_ok && ic_ok;
        wr.bias_we      = accept && (item.operation == OP_BIAS) && oc_ok;
        wr.second_half  = ic_half;
        wr.oc           = item.out_channel;
        wr.ic           = ic_half ? 6'(item.in_channel - 7'(MAX_IN_CHANNELS))
                                  : item.in_channel[5:0];
        wr.weight_value = item.weight_value;
        wr.bias_value   = item.bias_value;
    end

    // pixel request latches
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= 1'b0;
            do_upd_reg <= 1'b0;
            last_reg   <= 1'b0;
            eoi_reg    <= 1'b0;
        end
        else if (pixel_accept)
        begin
            first_reg  <= (chan_pos_reg == 6'd0);
            do_upd_reg <= ({1'b0, chan_pos_reg} < 7'(MAX_IN_CHANNELS));
            last_reg   <= (({1'b0, chan_pos_reg} + 7'd1) >= n_in);
            eoi_reg    <= item.last_pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            xa_reg <= item.inout_sample;
            xb_reg <= item.res_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= '0;
            chan_pos_reg  <= 6'd0;
            drain_idx_reg <= 6'd0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            chan_pos_reg  <= chan_pos_next;
            drain_idx_reg <= drain_idx_next;
        end
    end

    assign drain_last = ({1'b0, drain_idx_reg} == (n_out - 7'd1));
    assign merge_load = (state_reg == ST_DRAIN) && merge_free;

    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        chan_pos_next  = chan_pos_reg;
        drain_idx_next = drain_idx_reg;
        rd_pass        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // first weight pair is read while the request is taken
                if (pixel_accept)
                begin
                    state_next = ST_COMPUTE;
                    pass_next  = '0;
                end
            end
            ST_COMPUTE:
            begin
                rd_pass = PW'(pass_reg + 1'b1);
                if (pass_reg == LAST_PASS)
                begin
                    if (last_reg)
                    begin
                        chan_pos_next  = 6'd0;
                        drain_idx_next = 6'd0;
                        state_next     = ST_DRAIN;
                    end
                    else
                    begin
                        chan_pos_next = chan_pos_reg + 6'd1;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    pass_next = PW'(pass_reg + 1'b1);
                end
            end
            ST_DRAIN:
            begin
                if (merge_load)
                begin
                    drain_idx_next = drain_idx_reg + 6'd1;
                    if (drain_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign drain_shift = drain_idx_reg >> LANE_W;
    assign sel_pass    = (state_reg == ST_DRAIN) ? drain_shift[PW-1:0] : pass_reg;

    always_comb
    begin
        mac.upd_en  = (state_reg == ST_COMPUTE) && do_upd_reg;
        mac.first   = first_reg;
        mac.bias_en = bias_enable_reg;
        mac.xa      = xa_reg;
        mac.xb      = xb_reg;
    end

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        spic_lane #(
            .PASSES  (PASSES),
            .MAX_IN  (MAX_IN_CHANNELS),
            .LANE_ID (g)
        ) u_lane (
            .clk      (clk),
            .wr       (wr),
            .mac      (mac),
            .rd_ch    (chan_pos_reg),
            .rd_pass  (rd_pass),
            .sel_pass (sel_pass),
            .lane_sum (lane_sum[g])
        );
    end

    spic_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .lane_sum     (lane_sum),
        .load         (merge_load),
        .sel_lane     (drain_idx_reg[LANE_W-1:0]),
        .index        (drain_idx_reg),
        .last         (drain_last),
        .eoi          (eoi_reg),
        .result_stall (result_stall),
        .free         (merge_free),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ----- rtl/spic_checker.sv -----
// Port-level checks for the pointwise convolution block, bound to the top.
module spic_checker
    import spic_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // no new request while a pixel's sums are still going out
    a_stall_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_channel |-> item_stall)
        else $error("request accepted during drain");

    // sums of a pixel come back to back in channel order
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.last_channel |=>
            result_valid &&
            result.out_channel_index == $past(result.out_channel_index) + 6'd1)
        else $error("output channel order broken");

    // end-of-image flag is the same across one pixel
    a_eoi_steady: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.last_channel |=>
            result.end_of_image == $past(result.end_of_image))
        else $error("end_of_image changed within a pixel");

endmodule

bind split_input_pointwise_conv_int8 spic_checker u_spic_checker (.*);

// ----- bench/split_input_pointwise_conv_int8_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the split-input int8 pointwise convolution block.
module split_input_pointwise_conv_int8_tb;
    import spic_pkg::*;

    localparam int MAX_IN  = 64;
    localparam int MAX_OUT = 64;
    localparam int ROW     = 2 * MAX_IN;     // weight row: first half, then second half

    // Every pixel reads all output channels, so each setting here keeps
    // in_channels (after clamping) at or below this many filled channels.
    localparam int FILL_CH = 2;

    // Operation code the block has no use for; it must be swallowed silently.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // This covers any pixel request still in flight that produces no result
    // before registers are rewritten.
    localparam int SETTLE_CYCLES  = 20;
    localparam int HOLD_CYCLES    = 400;    // long result hold-off that backs up the block
    localparam int WATCHDOG_LIMIT = 4000;   // cycles without progress while work is pending

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       cfg_write_en = 1'b0;
    logic [1:0] cfg_index    = '0;
    logic [6:0] cfg_data     = '0;
    logic       item_valid   = 1'b0;
    logic       item_stall;
    item_t      item         = '0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    result_t    result;

    split_input_pointwise_conv_int8 u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the block: tables, accumulators, channel counter and
    // the three registers. Entries are only ever read after being written.
    // ------------------------------------------------------------------
    logic signed [7:0] weight_copy [0:MAX_OUT*ROW-1];
    logic [31:0]       bias_copy   [0:MAX_OUT-1];
    logic [31:0]       acc_copy    [0:MAX_OUT-1];
    int                chan_pos    = 0;
    logic [6:0]        in_ch_reg   = 7'd64;
    logic [6:0]        out_ch_reg  = 7'd64;
    logic              bias_en_reg = 1'b0;

    result_t expected_sums [$];     // sums still owed by the block, oldest first
    item_t   request_queue [$];     // requests waiting for the driver
    int      requests_queued = 0;
    int      requests_taken  = 0;
    int      fail_count      = 0;
    int      quiet_cycles    = 0;

    // Idle controls, set per phase by the stimulus process.
    logic sender_idles   = 1'b0;
    logic receiver_idles = 1'b0;
    int   holds_asked    = 0;

    // Channel counts outside 1..64 behave as if clamped.
    function automatic int channel_count(logic [6:0] v);
        if (v == 7'd0)
            return 1;
        if (v > 7'd64)
            return 64;
        return int'(v);
    endfunction

    // Update the shadow state with one accepted request and queue the sums
    // it completes (one per output channel, only at the end of a pixel).
    task automatic predict_sums(input item_t req);
        int      n_in;
        int      n_out;
        int      pa;
        int      pb;
        result_t r;
        n_in  = channel_count(in_ch_reg);
        n_out = channel_count(out_ch_reg);
        case (req.operation)
            OP_WEIGHT: weight_copy[req.out_channel * ROW + req.in_channel] = req.weight_value;
            OP_BIAS:   bias_copy[req.out_channel] = req.bias_value;
            OP_PIXEL:
            begin
                // Every output channel is updated (reloaded on the first input channel), whatever out_channels is.
                for (int o = 0; o < MAX_OUT; o++)
                begin
                    if (chan_pos == 0)
                        acc_copy[o] = bias_en_reg ? bias_copy[o] : 32'd0;
                    pa = int'(weight_copy[o * ROW + chan_pos]) * int'(req.inout_sample);
                    pb = int'(weight_copy[o * ROW + MAX_IN + chan_pos]) * int'(req.res_sample);
                    acc_copy[o] = acc_copy[o] + 32'(pa) + 32'(pb);
                end
                if (chan_pos + 1 >= n_in)
                begin
                    chan_pos = 0;
                    for (int o = 0; o < n_out; o++)
                    begin
                        r.out_channel_index = 6'(o);
                        r.sum               = acc_copy[o];
                        r.last_channel      = (o == n_out - 1);
                        r.end_of_image      = req.last_pixel;   // only the closing request counts
                        expected_sums.push_back(r);
                    end
                end
                else
                    chan_pos = chan_pos + 1;
            end
            default: ;  // unused code: no effect
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request driver: pops the queue, inserts random idle bursts, and holds
    // the payload steady while the block stalls.
    // ------------------------------------------------------------------
    int send_gap = 0;

    always @(posedge clk)
    begin
        if (rst_n && (!item_valid || !item_stall))
        begin
            if (send_gap > 0)
            begin
                item_valid <= 1'b0;
                send_gap   <= send_gap - 1;
            end
            else if (request_queue.size() != 0 && sender_idles && $urandom_range(0, 9) == 0)
            begin
                item_valid <= 1'b0;
                send_gap   <= $urandom_range(0, 11);
            end
            else if (request_queue.size() != 0)
            begin
                item_valid <= 1'b1;
                item       <= request_queue.pop_front();
            end
            else
                item_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stall bursts, plus long hold-offs on request of
    // the stimulus process, counted down here.
    // ------------------------------------------------------------------
    int stall_left = 0;
    int hold_left  = 0;
    int holds_done = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (holds_done != holds_asked)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES - 1;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (receiver_idles && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 11);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted sum against the oldest prediction,
    // predicts on each accepted request, and runs the progress watchdog.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_sums.size() == 0)
                begin
                    $error("unexpected result: out_channel_index %0d sum %0d",
                           result.out_channel_index, result.sum);
                    fail_count++;
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (result.out_channel_index !== want.out_channel_index)
                    begin
                        $error("out_channel_index: expected %0d, got %0d",
                               want.out_channel_index, result.out_channel_index);
                        fail_count++;
                    end
                    if (result.sum !== want.sum)
                    begin
                        $error("sum: expected %0d, got %0d", want.sum, result.sum);
                        fail_count++;
                    end
                    if (result.last_channel !== want.last_channel)
                    begin
                        $error("last_channel: expected %0b, got %0b",
                               want.last_channel, result.last_channel);
                        fail_count++;
                    end
                    if (result.end_of_image !== want.end_of_image)
                    begin
                        $error("end_of_image: expected %0b, got %0b",
                               want.end_of_image, result.end_of_image);
                        fail_count++;
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                predict_sums(item);
                requests_taken++;
            end
            // Only count silence while something is still owed.
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (requests_taken == requests_queued && expected_sums.size() == 0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send(input item_t req);
        request_queue.push_back(req);
        requests_queued++;
    endtask

    // Fully random request; unused fields toggle as well.
    function automatic item_t random_req(logic [1:0] op);
        logic [95:0] bits;
        item_t       req;
        bits = {$urandom, $urandom, $urandom};
        req  = bits[$bits(item_t)-1:0];
        req.operation = op;
        return req;
    endfunction

    function automatic item_t make_req(logic [1:0] op, logic [5:0] oc, logic [6:0] ic,
                                       logic [7:0] w, logic [31:0] b,
                                       logic [7:0] xa, logic [7:0] xb, logic lp);
        item_t req;
        req.operation    = op;
        req.out_channel  = oc;
        req.in_channel   = ic;
        req.weight_value = w;
        req.bias_value   = b;
        req.inout_sample = xa;
        req.res_sample   = xb;
        req.last_pixel   = lp;
        return req;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            REG_IN_CHANNELS:  in_ch_reg   = val;
            REG_OUT_CHANNELS: out_ch_reg  = val;
            REG_BIAS_ENABLE:  bias_en_reg = val[0];
            default: ;
        endcase
    endtask

    // Only called with nothing in flight.
    task automatic configure(logic [6:0] n_in, logic [6:0] n_out, logic bias_on);
        write_reg(REG_IN_CHANNELS, n_in);
        write_reg(REG_OUT_CHANNELS, n_out);
        write_reg(REG_BIAS_ENABLE, {6'd0, bias_on});
    endtask

    // Wait for every request to be taken and every sum to arrive, then let
    // any silent request finish inside the block.
    task automatic finish_phase();
        while (requests_taken != requests_queued || expected_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One setting, a run of whole pixels with table updates and unused codes
    // mixed in mid-pixel. calm turns idling off; squeeze asks for a long
    // result hold-off while requests keep coming.
    task automatic run_image(logic [6:0] n_in_reg, logic [6:0] n_out_reg, logic bias_on,
                             int pixels, logic calm, logic squeeze);
        item_t req;
        int    n_in;
        configure(n_in_reg, n_out_reg, bias_on);
        sender_idles   = !calm && ($urandom_range(0, 3) != 0);
        receiver_idles = !calm && ($urandom_range(0, 3) != 0);
        n_in = channel_count(in_ch_reg);
        for (int p = 0; p < pixels; p++)
        begin
            for (int c = 0; c < n_in; c++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send(random_req($urandom_range(0, 1) ? OP_BIAS : OP_WEIGHT));
                if ($urandom_range(0, 24) == 0)
                    send(random_req(OP_UNUSED));
                req = random_req(OP_PIXEL);
                if ($urandom_range(0, 7) == 0)
                    req.inout_sample = 8'h80;
                if ($urandom_range(0, 7) == 0)
                    req.res_sample = 8'h7f;
                send(req);
            end
        end
        if (squeeze)
            holds_asked++;
        finish_phase();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        item_t req;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every entry a pixel can read: all bias entries and the weights
        // of the first FILL_CH channels of both halves.
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        for (int oc = 0; oc < MAX_OUT; oc++)
        begin
            for (int c = 0; c < FILL_CH; c++)
            begin
                req = random_req(OP_WEIGHT);
                req.out_channel = 6'(oc);
                req.in_channel  = 7'(c);
                send(req);
                req = random_req(OP_WEIGHT);
                req.out_channel = 6'(oc);
                req.in_channel  = 7'(MAX_IN + c);
                send(req);
            end
            req = random_req(OP_BIAS);
            req.out_channel = 6'(oc);
            send(req);
        end
        finish_phase();

        // Directed: table extremes, sums that wrap both ways, last_pixel on a
        // non-closing request, an unused code and a weight rewrite mid-pixel.
        configure(7'd2, 7'd64, 1'b1);
        send(make_req(OP_WEIGHT, 6'd0, 7'd0, 8'h7f, 32'd0, 8'd0, 8'd0, 1'b0));
        send(make_req(OP_WEIGHT, 6'd63, 7'd65, 8'h80, 32'd0, 8'd0, 8'd0, 1'b0));
        send(make_req(OP_WEIGHT, 6'd63, 7'd127, 8'h80, 32'd0, 8'd0, 8'd0, 1'b0));
        send(make_req(OP_BIAS, 6'd0, 7'd0, 8'd0, 32'h7fff_ffff, 8'd0, 8'd0, 1'b0));
        send(make_req(OP_BIAS, 6'd63, 7'd0, 8'd0, 32'h8000_0000, 8'd0, 8'd0, 1'b0));
        send(make_req(OP_PIXEL, 6'd0, 7'd0, 8'd0, 32'd0, 8'h7f, 8'h80, 1'b1));
        send(random_req(OP_UNUSED));
        send(make_req(OP_WEIGHT, 6'd5, 7'd65, 8'h4d, 32'd0, 8'd0, 8'd0, 1'b0));
        send(make_req(OP_PIXEL, 6'd0, 7'd0, 8'd0, 32'd0, 8'h80, 8'h7f, 1'b0));
        send(make_req(OP_PIXEL, 6'd0, 7'd0, 8'd0, 32'd0, 8'h7f, 8'h7f, 1'b0));
        send(make_req(OP_PIXEL, 6'd0, 7'd0, 8'd0, 32'd0, 8'h80, 8'h80, 1'b1));
        finish_phase();

        // Zero channel counts act as one: each request is a whole pixel.
        configure(7'd0, 7'd0, 1'b0);
        send(make_req(OP_PIXEL, 6'd0, 7'd0, 8'd0, 32'd0, 8'h80, 8'h80, 1'b0));
        send(make_req(OP_PIXEL, 6'd0, 7'd0, 8'd0, 32'd0, 8'h7f, 8'h80, 1'b1));
        finish_phase();

        // Random images across settings, clamped out_channels included.
        run_image(7'd2, 7'd64, 1'b1, 8, 1'b0, 1'b0);
        run_image(7'd1, 7'd17, 1'b0, 14, 1'b0, 1'b0);
        run_image(7'd1, 7'd64, 1'b1, 30, 1'b0, 1'b1);    // backs the block up
        run_image(7'd2, 7'd127, 1'b0, 6, 1'b0, 1'b0);
        run_image(7'd2, 7'd1, 1'b1, 15, 1'b0, 1'b0);
        run_image(7'd2, 7'd3, 1'b1, 8, 1'b1, 1'b0);      // no idling at the tail

        if (fail_count == 0 && expected_sums.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
